>>> rtl/mpv_pkg.sv
package mpv_pkg;

    localparam logic CMD_LEAF    = 1'b0;
    localparam logic CMD_SIBLING = 1'b1;

    localparam logic [1:0] CFG_ROOT0 = 2'd0;
    localparam logic [1:0] CFG_ROOT1 = 2'd1;
    localparam logic [1:0] CFG_ROOT2 = 2'd2;
    localparam logic [1:0] CFG_ROOT3 = 2'd3;

    localparam logic [31:0] SM3_T_LOW  = 32'h79cc4519;
    localparam logic [31:0] SM3_T_HIGH = 32'h7a879d8a;

    localparam logic [255:0] SM3_IV = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    localparam logic [511:0] SM3_PAD_BLOCK = {32'h80000000, 448'd0, 32'd512};

    typedef struct packed {
        logic        cmd;
        logic [63:0] digest_word0;
        logic [63:0] digest_word1;
        logic [63:0] digest_word2;
        logic [63:0] digest_word3;
        logic [31:0] leaf_index;
        logic        ends_proof;
    } in_item_t;

    typedef struct packed {
        logic        proof_valid;
        logic [63:0] computed_word0;
        logic [63:0] computed_word1;
        logic [63:0] computed_word2;
        logic [63:0] computed_word3;
    } out_item_t;

    typedef struct packed {
        logic         is_sibling;
        logic         ends_proof;
        logic [255:0] digest;
        logic [31:0]  leaf_index;
    } req_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

>>> rtl/mpv_front.sv
module mpv_front
    import mpv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_valid,
    input  logic     q_take,
    output req_t     q_data
);

    req_t q_mem_reg [2];
    logic q_wp_reg;
    logic q_rp_reg;
    logic [1:0] q_cnt_reg;
    logic push;
    logic pop;

    assign in_stall = (q_cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (q_cnt_reg != 2'd0);
    assign pop = q_valid && q_take;
    assign q_data = q_mem_reg[q_rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[q_wp_reg].is_sibling <= (in_data.cmd == CMD_SIBLING);
            q_mem_reg[q_wp_reg].ends_proof <= in_data.ends_proof;
            q_mem_reg[q_wp_reg].digest <= {in_data.digest_word0, in_data.digest_word1,
                                           in_data.digest_word2, in_data.digest_word3};
            q_mem_reg[q_wp_reg].leaf_index <= in_data.leaf_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg <= 1'b0;
            q_rp_reg <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                q_wp_reg <= ~q_wp_reg;
            if (pop)
                q_rp_reg <= ~q_rp_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> rtl/mpv_sm3_core.sv
module mpv_sm3_core
    import mpv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] iv,
    input  logic [511:0] block,
    output logic         done,
    output logic [255:0] digest
);

    typedef enum logic { IDLE, RUN } state_t;

    state_t        state_reg;
    logic [5:0]    round_reg;
    logic [31:0]   w_reg [16];
    logic [31:0]   v_reg [8];
    logic [31:0]   a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic          done_reg;

    logic [31:0] w_new, tj, a12, ss1, ss2, ff, gg, tt1, tt2;

    always_comb
    begin
        w_new = perm1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 5'd15))
                ^ rotl(w_reg[3], 5'd7) ^ w_reg[10];
        tj = (round_reg < 6'd16) ? SM3_T_LOW : SM3_T_HIGH;
        a12 = rotl(a_reg, 5'd12);
        ss1 = rotl(a12 + e_reg + rotl(tj, round_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (round_reg < 6'd16)
        begin
            ff = a_reg ^ b_reg ^ c_reg;
            gg = e_reg ^ f_reg ^ g_reg;
        end
        else
        begin
            ff = (a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg);
            gg = (e_reg & f_reg) | (~e_reg & g_reg);
        end
        tt1 = ff + d_reg + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + h_reg + ss1 + w_reg[0];
    end

    assign done = done_reg;
    assign digest = {v_reg[0] ^ a_reg, v_reg[1] ^ b_reg, v_reg[2] ^ c_reg, v_reg[3] ^ d_reg,
                     v_reg[4] ^ e_reg, v_reg[5] ^ f_reg, v_reg[6] ^ g_reg, v_reg[7] ^ h_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == IDLE && start)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= iv[255 - 32*i -: 32];
            {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg} <= iv;
        end
        else if (state_reg == RUN)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            d_reg <= c_reg;
            c_reg <= rotl(b_reg, 5'd9);
            b_reg <= a_reg;
            a_reg <= tt1;
            h_reg <= g_reg;
            g_reg <= rotl(f_reg, 5'd19);
            f_reg <= e_reg;
            e_reg <= perm0(tt2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            round_reg <= 6'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= RUN;
                        round_reg <= 6'd0;
                    end
                end
                RUN:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= IDLE;
                        done_reg <= 1'b1;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

>>> rtl/mpv_back.sv
module mpv_back
    import mpv_pkg::*;
#(
    parameter int INDEX_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    output logic         q_take,
    input  req_t         q_data,
    input  logic [255:0] root,
    output logic         out_valid,
    input  logic         out_stall,
    output out_item_t    out_data
);

    typedef enum logic [2:0] { IDLE, H1_START, H1_WAIT, H2_START, H2_WAIT, EMIT } state_t;

    state_t                 state_reg;
    logic [255:0]           run_reg;
    logic [INDEX_BITS-1:0]  pos_reg;
    logic [255:0]           sib_reg;
    logic                   ends_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;
    logic                   core_start;
    logic [255:0]           core_iv;
    logic [511:0]           core_block;
    logic                   core_done;
    logic [255:0]           core_digest;
    logic [255:0]           mid_reg;
    logic [INDEX_BITS-1:0]  idx_load;

    generate
        if (INDEX_BITS >= 32)
        begin : g_wide
            assign idx_load = INDEX_BITS'(q_data.leaf_index);
        end
        else
        begin : g_narrow
            assign idx_load = q_data.leaf_index[INDEX_BITS-1:0];
        end
    endgenerate

    mpv_sm3_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (core_start),
        .iv     (core_iv),
        .block  (core_block),
        .done   (core_done),
        .digest (core_digest)
    );

    assign core_start = (state_reg == H1_START) || (state_reg == H2_START);
    assign core_iv = (state_reg == H1_START) ? SM3_IV : mid_reg;
    assign core_block = (state_reg == H2_START) ? SM3_PAD_BLOCK :
                        (pos_reg[0] ? {sib_reg, run_reg} : {run_reg, sib_reg});
    assign q_take = (state_reg == IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            sib_reg <= q_data.digest;
            ends_reg <= q_data.ends_proof;
        end
        if (core_done && state_reg == H1_WAIT)
            mid_reg <= core_digest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            run_reg <= '0;
            pos_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != EMIT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_data.is_sibling)
                            state_reg <= H1_START;
                        else
                        begin
                            run_reg <= q_data.digest;
                            pos_reg <= idx_load;
                            state_reg <= q_data.ends_proof ? EMIT : IDLE;
                        end
                    end
                end
                H1_START: state_reg <= H1_WAIT;
                H1_WAIT:  if (core_done) state_reg <= H2_START;
                H2_START: state_reg <= H2_WAIT;
                H2_WAIT:
                begin
                    if (core_done)
                    begin
                        run_reg <= core_digest;
                        pos_reg <= pos_reg >> 1;
                        state_reg <= ends_reg ? EMIT : IDLE;
                    end
                end
                EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.proof_valid <= (run_reg == root);
                        out_reg.computed_word0 <= run_reg[255:192];
                        out_reg.computed_word1 <= run_reg[191:128];
                        out_reg.computed_word2 <= run_reg[127:64];
                        out_reg.computed_word3 <= run_reg[63:0];
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

>>> rtl/merkle_proof_verifier_unit.sv
// Merkle path verifier with SM3. A leaf request loads the running hash and,
// when it ends a proof, passes through the emit state; a sibling request
// holds the hash side through two chained 64-round compressions in one
// shared SM3 round unit (one round per cycle) plus start and hand-off states.
// A two-entry queue takes requests while the hash runs; the result register
// waits for the sink.
module merkle_proof_verifier_unit
    import mpv_pkg::*;
#(
    parameter int INDEX_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] root_reg [4];
    logic        q_valid;
    logic        q_take;
    req_t        q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                root_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROOT0: root_reg[0] <= cfg_data;
                CFG_ROOT1: root_reg[1] <= cfg_data;
                CFG_ROOT2: root_reg[2] <= cfg_data;
                CFG_ROOT3: root_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    mpv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_data   (q_data)
    );

    mpv_back #(.INDEX_BITS(INDEX_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_data    (q_data),
        .root      ({root_reg[0], root_reg[1], root_reg[2], root_reg[3]}),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result dropped under stall");
    a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid)
        else $error("queue popped while empty");
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> !q_take || q_valid)
        else $error("queue state inconsistent");
`endif

endmodule
